[rtl/core/spp_pkg.sv]
// Shared types and constants for the servo packet parser.
`default_nettype none
package spp_pkg;

   localparam logic [7:0] HDR_BYTE = 8'hFF;
   localparam logic [5:0] LEN_OVERHEAD = 6'd2;

   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_PARAM = 2'd1;
   localparam logic [1:0] CMD_PACKET = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic bad;
      logic [7:0] data;
      logic [5:0] index;
      logic [7:0] id;
      logic [7:0] instr;
      logic [5:0] count;
   } cmd_type;

   typedef struct packed {
      logic status;
      logic complete;
      logic [7:0] packet_id;
      logic [7:0] instruction;
      logic [5:0] param_count;
      logic [5:0] param_index;
      logic [7:0] param_byte;
      logic last;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/spp_front.sv]
// Front end: header hunt, field capture and checksum, one command per byte.
`default_nettype none
module spp_front #(
   parameter int BUFFER_CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept_i,
   input wire logic [7:0] byte_i,
   output spp_pkg::cmd_type cmd_o
);

   localparam logic [2:0] PH_HEAD1 = 3'd0;
   localparam logic [2:0] PH_HEAD2 = 3'd1;
   localparam logic [2:0] PH_ID = 3'd2;
   localparam logic [2:0] PH_LEN = 3'd3;
   localparam logic [2:0] PH_INSTR = 3'd4;
   localparam logic [2:0] PH_PARAM = 3'd5;
   localparam logic [2:0] PH_CHECK = 3'd6;

   localparam logic [8:0] CAP = 9'(BUFFER_CAPACITY);

   logic [2:0] phase_ff, phase_in;
   logic [5:0] pos_ff, pos_in;
   logic [7:0] id_ff, id_in;
   logic [5:0] len_ff, len_in;
   logic [7:0] instr_ff, instr_in;
   logic [7:0] sum_ff, sum_in;
   logic [5:0] count;
   logic [5:0] pos_nx;

   assign count = len_ff - spp_pkg::LEN_OVERHEAD;
   assign pos_nx = pos_ff + 6'd1;

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      id_in = id_ff;
      len_in = len_ff;
      instr_in = instr_ff;
      sum_in = sum_ff;
      cmd_o = '0;
      cmd_o.op = spp_pkg::CMD_STATUS;
      case (phase_ff)
         PH_HEAD2: begin
            if (byte_i == spp_pkg::HDR_BYTE) begin
               phase_in = PH_ID;
            end else begin
               phase_in = PH_HEAD1;
               cmd_o.bad = 1'b1;
            end
         end
         PH_ID: begin
            id_in = byte_i;
            sum_in = byte_i;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (({1'b0, byte_i} + 9'd4 > CAP) || (byte_i < 8'd2)) begin
               phase_in = PH_HEAD1;
               cmd_o.bad = 1'b1;
            end else begin
               len_in = byte_i[5:0];
               sum_in = sum_ff + byte_i;
               phase_in = PH_INSTR;
            end
         end
         PH_INSTR: begin
            instr_in = byte_i;
            sum_in = sum_ff + byte_i;
            if (len_ff > 6'd2) begin
               pos_in = '0;
               phase_in = PH_PARAM;
            end else begin
               phase_in = PH_CHECK;
            end
         end
         PH_PARAM: begin
            cmd_o.op = spp_pkg::CMD_PARAM;
            cmd_o.data = byte_i;
            cmd_o.index = pos_ff;
            sum_in = sum_ff + byte_i;
            pos_in = pos_nx;
            if (pos_nx == count) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            phase_in = PH_HEAD1;
            if (~sum_ff != byte_i) begin
               cmd_o.bad = 1'b1;
            end else begin
               cmd_o.op = spp_pkg::CMD_PACKET;
               cmd_o.id = id_ff;
               cmd_o.instr = instr_ff;
               cmd_o.count = count;
            end
         end
         default: begin
            phase_in = (byte_i == spp_pkg::HDR_BYTE) ? PH_HEAD2 : PH_HEAD1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         pos_ff <= '0;
         id_ff <= '0;
         len_ff <= '0;
         instr_ff <= '0;
         sum_ff <= '0;
      end else if (accept_i) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         id_ff <= id_in;
         len_ff <= len_in;
         instr_ff <= instr_in;
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/spp_cmd_queue.sv]
// Short command queue between the front and back ends.
`default_nettype none
module spp_cmd_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push_i,
   input spp_pkg::cmd_type data_i,
   output logic full_o,
   input wire logic pop_i,
   output logic empty_o,
   output spp_pkg::cmd_type data_o
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);

   spp_pkg::cmd_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] fill_ff;
   logic do_push, do_pop;

   assign full_o = (fill_ff == (AW+1)'(DEPTH));
   assign empty_o = (fill_ff == '0);
   assign data_o = slot_ff[rd_ff];
   assign do_push = push_i && !full_o;
   assign do_pop = pop_i && !empty_o;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/spp_back.sv]
// Back end: parameter store and result sequencer with output register.
`default_nettype none
module spp_back #(
   parameter int BUFFER_CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_empty_i,
   input spp_pkg::cmd_type cmd_i,
   output logic cmd_pop_o,
   output logic rsp_empty_o,
   input wire logic rsp_pop_i,
   output spp_pkg::rsp_type rsp_o
);

   localparam int DEPTH = BUFFER_CAPACITY - 4;
   localparam int AW = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   logic [1:0] state_ff, state_in;
   logic [5:0] idx_ff, idx_in;
   logic [7:0] pid_ff, pid_in;
   logic [7:0] pinstr_ff, pinstr_in;
   logic [5:0] pcount_ff, pcount_in;
   logic out_valid_ff, out_valid_in;
   spp_pkg::rsp_type out_ff, out_in;
   logic slot_free;
   logic wr_en;
   logic is_last;

   assign slot_free = !out_valid_ff || rsp_pop_i;
   assign is_last = ((idx_ff + 6'd1) == pcount_ff);
   assign rsp_empty_o = !out_valid_ff;
   assign rsp_o = out_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      pid_in = pid_ff;
      pinstr_in = pinstr_ff;
      pcount_in = pcount_ff;
      out_valid_in = out_valid_ff && !rsp_pop_i;
      out_in = out_ff;
      cmd_pop_o = 1'b0;
      wr_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty_i && slot_free) begin
               cmd_pop_o = 1'b1;
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.last = 1'b1;
               case (cmd_i.op)
                  spp_pkg::CMD_PARAM: begin
                     wr_en = 1'b1;
                  end
                  spp_pkg::CMD_PACKET: begin
                     if (cmd_i.count == '0) begin
                        out_in.complete = 1'b1;
                        out_in.packet_id = cmd_i.id;
                        out_in.instruction = cmd_i.instr;
                     end else begin
                        out_valid_in = out_valid_ff && !rsp_pop_i;
                        out_in = out_ff;
                        pid_in = cmd_i.id;
                        pinstr_in = cmd_i.instr;
                        pcount_in = cmd_i.count;
                        idx_in = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     out_in.status = cmd_i.bad;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in.status = 1'b0;
               out_in.complete = 1'b1;
               out_in.packet_id = pid_ff;
               out_in.instruction = pinstr_ff;
               out_in.param_count = pcount_ff;
               out_in.param_index = idx_ff;
               out_in.param_byte = rd_data_ff;
               out_in.last = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 6'd1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[cmd_i.index[AW-1:0]] <= cmd_i.data;
      end
      rd_data_ff <= store_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pid_ff <= pid_in;
      pinstr_ff <= pinstr_in;
      pcount_ff <= pcount_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

[rtl/core/servo_packet_parser.sv]
// Top level of the servo instruction packet parser.
//
//   channel   direction  handshake             payload
//   req       in         req_push / req_full   req_rx_byte
//   rsp       out        rsp_pop / rsp_empty   status, complete, packet_id, instruction,
//                                              param_count, param_index, param_byte, last
//
// A byte request is taken while the command queue has room.
// A plain byte's result reaches the result ports through the command queue and output register.
// A valid packet's parameters follow its checksum byte, each through the read state and its
// registered store read, then the send state and output register; no command is popped meanwhile.
// Reset clears the parse state, queue, back-end state and output valid flag; the store needs none.
// Either side may stall: the four-entry command queue and output register absorb it.
`default_nettype none
module servo_packet_parser #(
   parameter int BUFFER_CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire logic [7:0] req_rx_byte,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output logic rsp_status,
   output logic rsp_complete,
   output logic [7:0] rsp_packet_id,
   output logic [7:0] rsp_instruction,
   output logic [5:0] rsp_param_count,
   output logic [5:0] rsp_param_index,
   output logic [7:0] rsp_param_byte,
   output logic rsp_last
);

   spp_pkg::cmd_type front_cmd;
   spp_pkg::cmd_type queue_cmd;
   spp_pkg::rsp_type rsp;
   logic accept;
   logic queue_empty;
   logic queue_pop;

   assign accept = req_push && !req_full;

   spp_front #(
      .BUFFER_CAPACITY(BUFFER_CAPACITY)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept_i(accept),
      .byte_i(req_rx_byte),
      .cmd_o(front_cmd)
   );

   spp_cmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_i(accept),
      .data_i(front_cmd),
      .full_o(req_full),
      .pop_i(queue_pop),
      .empty_o(queue_empty),
      .data_o(queue_cmd)
   );

   spp_back #(
      .BUFFER_CAPACITY(BUFFER_CAPACITY)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_empty_i(queue_empty),
      .cmd_i(queue_cmd),
      .cmd_pop_o(queue_pop),
      .rsp_empty_o(rsp_empty),
      .rsp_pop_i(rsp_pop),
      .rsp_o(rsp)
   );

   assign rsp_status = rsp.status;
   assign rsp_complete = rsp.complete;
   assign rsp_packet_id = rsp.packet_id;
   assign rsp_instruction = rsp.instruction;
   assign rsp_param_count = rsp.param_count;
   assign rsp_param_index = rsp.param_index;
   assign rsp_param_byte = rsp.param_byte;
   assign rsp_last = rsp.last;

endmodule
`default_nettype wire

[tb/servo_packet_parser_tb.sv]
// Self-checking testbench for the servo packet parser: directed framing cases and random streams.
`timescale 1ns / 1ps
module servo_packet_parser_tb;

   localparam int CAPACITY = 64;
   localparam int FRAME_OVERHEAD = 4;
   localparam int MAX_PARAMS = CAPACITY - FRAME_OVERHEAD - 2;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 20;
   localparam int SHOWN_ERRORS = 10;

   localparam logic [2:0] FR_HEAD1 = 3'd0;
   localparam logic [2:0] FR_HEAD2 = 3'd1;
   localparam logic [2:0] FR_ID = 3'd2;
   localparam logic [2:0] FR_LEN = 3'd3;
   localparam logic [2:0] FR_INSTR = 3'd4;
   localparam logic [2:0] FR_PARAM = 3'd5;
   localparam logic [2:0] FR_CHECK = 3'd6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_status;
   logic rsp_complete;
   logic [7:0] rsp_packet_id;
   logic [7:0] rsp_instruction;
   logic [5:0] rsp_param_count;
   logic [5:0] rsp_param_index;
   logic [7:0] rsp_param_byte;
   logic rsp_last;

   // deframer shadow state
   logic [2:0] fr_state = FR_HEAD1;
   logic [5:0] fr_fill = '0;
   logic [7:0] fr_id = '0;
   logic [5:0] fr_len = '0;
   logic [7:0] fr_instr = '0;
   logic [7:0] fr_sum = '0;
   logic [7:0] fr_params [0:MAX_PARAMS-1];

   spp_pkg::rsp_type rsp_due [$];
   int mismatches = 0;
   int bytes_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   servo_packet_parser #(
      .BUFFER_CAPACITY(CAPACITY)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_complete(rsp_complete),
      .rsp_packet_id(rsp_packet_id),
      .rsp_instruction(rsp_instruction),
      .rsp_param_count(rsp_param_count),
      .rsp_param_index(rsp_param_index),
      .rsp_param_byte(rsp_param_byte),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic bad;
      logic [5:0] n_params;
      spp_pkg::rsp_type r;
      bad = 1'b0;
      r = '0;
      case (fr_state)
         FR_HEAD2: begin
            if (b == spp_pkg::HDR_BYTE) begin
               fr_state = FR_ID;
            end else begin
               fr_state = FR_HEAD1;
               bad = 1'b1;
            end
         end
         FR_ID: begin
            fr_id = b;
            fr_sum = b;
            fr_state = FR_LEN;
         end
         FR_LEN: begin
            if (int'(b) + FRAME_OVERHEAD > CAPACITY || b < 8'(spp_pkg::LEN_OVERHEAD)) begin
               fr_state = FR_HEAD1;
               bad = 1'b1;
            end else begin
               fr_len = b[5:0];
               fr_sum = fr_sum + b;
               fr_state = FR_INSTR;
            end
         end
         FR_INSTR: begin
            fr_instr = b;
            fr_sum = fr_sum + b;
            if (fr_len > spp_pkg::LEN_OVERHEAD) begin
               fr_fill = '0;
               fr_state = FR_PARAM;
            end else begin
               fr_state = FR_CHECK;
            end
         end
         FR_PARAM: begin
            fr_params[fr_fill] = b;
            fr_sum = fr_sum + b;
            fr_fill = fr_fill + 6'd1;
            if (fr_fill == fr_len - spp_pkg::LEN_OVERHEAD) begin
               fr_state = FR_CHECK;
            end
         end
         FR_CHECK: begin
            fr_state = FR_HEAD1;
            if (~fr_sum != b) begin
               bad = 1'b1;
            end else begin
               n_params = fr_len - spp_pkg::LEN_OVERHEAD;
               r.complete = 1'b1;
               r.packet_id = fr_id;
               r.instruction = fr_instr;
               r.param_count = n_params;
               if (n_params == 6'd0) begin
                  r.last = 1'b1;
                  rsp_due.push_back(r);
               end
               for (int i = 0; i < int'(n_params); i++) begin
                  r.param_index = 6'(i);
                  r.param_byte = fr_params[i];
                  r.last = (i == int'(n_params) - 1);
                  rsp_due.push_back(r);
               end
               return;
            end
         end
         default: begin
            fr_state = (b == spp_pkg::HDR_BYTE) ? FR_HEAD2 : FR_HEAD1;
         end
      endcase
      r.status = bad;
      r.last = 1'b1;
      rsp_due.push_back(r);
   endfunction

   task automatic report_mismatch(string why, spp_pkg::rsp_type want, spp_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%0t %s: exp st=%b cp=%b id=%h ins=%h cnt=%0d idx=%0d byte=%h last=%b",
                  $time, why, want.status, want.complete, want.packet_id, want.instruction,
                  want.param_count, want.param_index, want.param_byte, want.last);
         $display("   got st=%b cp=%b id=%h ins=%h cnt=%0d idx=%0d byte=%h last=%b",
                  got.status, got.complete, got.packet_id, got.instruction,
                  got.param_count, got.param_index, got.param_byte, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         deframe_byte(req_rx_byte);
      end
   end

   always @(posedge clock) begin
      spp_pkg::rsp_type want;
      spp_pkg::rsp_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.status = rsp_status;
         got.complete = rsp_complete;
         got.packet_id = rsp_packet_id;
         got.instruction = rsp_instruction;
         got.param_count = rsp_param_count;
         got.param_index = rsp_param_index;
         got.param_byte = rsp_param_byte;
         got.last = rsp_last;
         if (rsp_due.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = rsp_due.pop_front();
            if (want.status !== got.status || want.complete !== got.complete ||
                want.packet_id !== got.packet_id || want.instruction !== got.instruction ||
                want.param_count !== got.param_count || want.param_index !== got.param_index ||
                want.param_byte !== got.param_byte || want.last !== got.last) begin
               report_mismatch("result mismatch", want, got);
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_packet(logic [7:0] id, logic [7:0] instr, int n_params, bit good_sum);
      logic [7:0] sum;
      logic [7:0] data;
      logic [7:0] len;
      len = 8'(n_params + 2);
      sum = id + len + instr;
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(id);
      send_byte(len);
      send_byte(instr);
      for (int i = 0; i < n_params; i++) begin
         data = rand_byte();
         sum = sum + data;
         send_byte(data);
      end
      send_byte(good_sum ? ~sum : (~sum ^ 8'($urandom_range(1, 255))));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (rsp_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_traffic(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic test_framing_cases();
      set_traffic(0, 0);
      send_byte(8'h00);
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(8'h00);
      // length below minimum
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(8'h00);
      send_byte(8'h01);
      // length one past the buffer, id all ones
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(spp_pkg::HDR_BYTE);
      send_byte(8'hFF);
      send_byte(8'(CAPACITY - FRAME_OVERHEAD + 1));
      send_packet(8'h00, 8'hFF, 0, 1'b1);
      send_packet(8'hFE, 8'h00, 1, 1'b0);
      drain();
   endtask

   task automatic test_largest_packet();
      set_traffic(0, 0);
      send_packet(rand_byte(), rand_byte(), MAX_PARAMS, 1'b1);
      drain();
   endtask

   task automatic random_stream(int n_bytes);
      int start;
      int pick;
      int n_params;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            n_params = ($urandom_range(99) < 4) ? $urandom_range(MAX_PARAMS)
                                                : $urandom_range(6);
            send_packet(rand_byte(), rand_byte(), n_params, $urandom_range(99) < 85);
         end else if (pick < 80) begin
            send_byte(rand_byte());
         end else if (pick < 88) begin
            send_byte(spp_pkg::HDR_BYTE);
            send_byte(rand_byte());
         end else begin
            // arbitrary length; a valid one swallows what follows
            send_byte(spp_pkg::HDR_BYTE);
            send_byte(spp_pkg::HDR_BYTE);
            send_byte(rand_byte());
            send_byte(rand_byte());
         end
      end
      drain();
   endtask

   task automatic test_random_traffic();
      set_traffic(0, 0);
      random_stream(35);
      set_traffic(86, 0);
      random_stream(35);
      set_traffic(0, 86);
      random_stream(35);
      set_traffic(18, 18);
      random_stream(35);
   endtask

   task automatic test_receiver_hold();
      set_traffic(0, 0);
      hold_start = 1'b1;
      repeat (3) begin
         send_packet(rand_byte(), rand_byte(), $urandom_range(6), 1'b1);
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_framing_cases();
      test_largest_packet();
      test_random_traffic();
      test_receiver_hold();
      set_traffic(0, 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $display("%0d expected results never arrived", rsp_due.size());
      end
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
